>>> rtl/sodfs_pkg.sv
// ----------------------------------------------------------------------------
// sodfs_pkg
// Shared types, constants and helpers of the send-on-delta frame scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sodfs_pkg;

    localparam int SAMPLE_BITS_DEF = 10;
    localparam int TIME_BITS_DEF   = 32;
    localparam int MAX_SAMPLE_BITS = 16;

    localparam int INTERVAL_BITS = 16;
    localparam int THRESH_BITS   = 10;
    localparam int ID_BITS       = 11;
    localparam int HASH_BITS     = 32;
    localparam int SINGLE_BITS   = 32;
    localparam int PAYLOAD_BITS  = HASH_BITS + SINGLE_BITS;

    localparam int APB_ADDR_BITS = 5;
    localparam int APB_DATA_BITS = 32;

    localparam int FIFO_DEPTH = 4;

    localparam logic [INTERVAL_BITS-1:0] READ_INTERVAL_RST = 16'd10;
    localparam logic [INTERVAL_BITS-1:0] FAST_INTERVAL_RST = 16'd25;
    localparam logic [INTERVAL_BITS-1:0] SLOW_INTERVAL_RST = 16'd500;
    localparam logic [THRESH_BITS-1:0]   THRESHOLD_RST     = 10'd2;
    localparam logic [ID_BITS-1:0]       FRAME_ID_RST      = 11'h781;
    localparam logic [HASH_BITS-1:0]     ANALOG_HASH_RST   = 32'd595545759;
    localparam logic [HASH_BITS-1:0]     SWITCH_HASH_RST   = 32'd2138825443;

    localparam logic [SINGLE_BITS-1:0] SINGLE_ONE  = 32'h3F80_0000;
    localparam logic [SINGLE_BITS-1:0] SINGLE_ZERO = 32'h0000_0000;

    localparam logic CH_ANALOG = 1'b0;
    localparam logic CH_SWITCH = 1'b1;

    typedef enum logic [2:0] {
        REG_READ_INTERVAL = 3'd0,
        REG_FAST_INTERVAL = 3'd1,
        REG_SLOW_INTERVAL = 3'd2,
        REG_THRESHOLD     = 3'd3,
        REG_FRAME_ID      = 3'd4,
        REG_ANALOG_HASH   = 3'd5,
        REG_SWITCH_HASH   = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic [INTERVAL_BITS-1:0] read_interval;
        logic [INTERVAL_BITS-1:0] fast_interval;
        logic [INTERVAL_BITS-1:0] slow_interval;
        logic [THRESH_BITS-1:0]   threshold;
        logic [ID_BITS-1:0]       frame_id;
        logic [HASH_BITS-1:0]     analog_hash;
        logic [HASH_BITS-1:0]     switch_hash;
    } cfg_t;

    typedef struct packed {
        logic [ID_BITS-1:0]      frame_id;
        logic                    channel;
        logic [PAYLOAD_BITS-1:0] payload;
        logic                    last_of_tick;
    } frame_t;

    typedef struct packed {
        logic [1:0] count;
        frame_t     first;
        frame_t     second;
    } push_t;

    // Exact single-precision bits of a small non-negative integer.
    function automatic logic [SINGLE_BITS-1:0] int_to_single(
        input logic [MAX_SAMPLE_BITS-1:0] v
    );
        logic [4:0]             p;
        logic [SINGLE_BITS-1:0] wide;
        p = '0;
        for (int i = 1; i < MAX_SAMPLE_BITS; i++) begin
            if (v[i]) begin
                p = 5'(i);
            end
        end
        wide = SINGLE_BITS'(v) << (5'd23 - p);
        if (v == '0) begin
            return SINGLE_ZERO;
        end
        return {1'b0, 8'(8'd127 + {3'b000, p}), wide[22:0]};
    endfunction

endpackage

`default_nettype wire

>>> rtl/sodfs_tick_if.sv
// ----------------------------------------------------------------------------
// sodfs_tick_if
// Input channel: one millisecond tick with an analog sample and a switch level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sodfs_tick_if #(
    parameter int SAMPLE_BITS = sodfs_pkg::SAMPLE_BITS_DEF
);
    logic                   valid;
    logic                   ready;
    logic [SAMPLE_BITS-1:0] analog_sample;
    logic                   switch_level;

    modport source (output valid, output analog_sample, output switch_level, input ready);
    modport sink   (input valid, input analog_sample, input switch_level, output ready);
endinterface

`default_nettype wire

>>> rtl/sodfs_frame_if.sv
// ----------------------------------------------------------------------------
// sodfs_frame_if
// Output channel: one emitted frame per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface sodfs_frame_if;
    logic                                valid;
    logic                                ready;
    logic [sodfs_pkg::ID_BITS-1:0]       frame_id;
    logic                                channel;
    logic [sodfs_pkg::PAYLOAD_BITS-1:0]  payload;
    logic                                last_of_tick;

    modport source (output valid, output frame_id, output channel, output payload,
                    output last_of_tick, input ready);
    modport sink   (input valid, input frame_id, input channel, input payload,
                    input last_of_tick, output ready);
endinterface

`default_nettype wire

>>> rtl/send_on_delta_frame_scheduler_unit.sv
// ----------------------------------------------------------------------------
// send_on_delta_frame_scheduler_unit
// Send-on-delta frame scheduler with heartbeat for an analog and a switch
// channel, configured over APB.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake            Carries
//   tick      in         valid / ready        analog_sample, switch_level
//   frame     out        valid / ready        frame_id, channel, payload, last_of_tick
//   apb       in/out     psel, penable, pwrite  register writes and reads
//
// A tick enters the input register and is decided once the frame queue has
// room for two frames; zero, one or two frames are queued.
// Frames leave one per cycle while frame.ready is high, through the single frame
// port; a new tick is taken in the same cycle as the held one is decided.
// Reset clears all channel state and the queue at once; no clearing pass.
// A stalled frame port lets the four-entry queue grow past two frames, then the
// input register holds and tick.ready falls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module send_on_delta_frame_scheduler_unit #(
    parameter int SAMPLE_BITS = sodfs_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = sodfs_pkg::TIME_BITS_DEF
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [sodfs_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [sodfs_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [sodfs_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                      pready,
    sodfs_tick_if.sink                                tick,
    sodfs_frame_if.source                             frame
);

    sodfs_pkg::cfg_t  cfg;
    sodfs_pkg::push_t push;
    logic             room;

    sodfs_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    sodfs_core #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .TIME_BITS   (TIME_BITS)
    ) u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .tick  (tick),
        .room  (room),
        .push  (push)
    );

    sodfs_frame_fifo u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .room  (room),
        .frame (frame)
    );

endmodule

`default_nettype wire

>>> rtl/sodfs_apb_regs.sv
// ----------------------------------------------------------------------------
// sodfs_apb_regs
// APB configuration registers of the frame scheduler.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sodfs_apb_regs (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [sodfs_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [sodfs_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic      [sodfs_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                                      pready,
    output sodfs_pkg::cfg_t                           cfg
);

    sodfs_pkg::cfg_t     cfg_reg;
    sodfs_pkg::cfg_t     cfg_next;
    sodfs_pkg::reg_idx_t idx;
    logic                wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign idx    = sodfs_pkg::reg_idx_t'(paddr[sodfs_pkg::APB_ADDR_BITS-1:2]);
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (idx)
                sodfs_pkg::REG_READ_INTERVAL: cfg_next.read_interval = pwdata[15:0];
                sodfs_pkg::REG_FAST_INTERVAL: cfg_next.fast_interval = pwdata[15:0];
                sodfs_pkg::REG_SLOW_INTERVAL: cfg_next.slow_interval = pwdata[15:0];
                sodfs_pkg::REG_THRESHOLD:     cfg_next.threshold     = pwdata[9:0];
                sodfs_pkg::REG_FRAME_ID:      cfg_next.frame_id      = pwdata[10:0];
                sodfs_pkg::REG_ANALOG_HASH:   cfg_next.analog_hash   = pwdata;
                sodfs_pkg::REG_SWITCH_HASH:   cfg_next.switch_hash   = pwdata;
                default:                      cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            sodfs_pkg::REG_READ_INTERVAL: prdata = 32'(cfg_reg.read_interval);
            sodfs_pkg::REG_FAST_INTERVAL: prdata = 32'(cfg_reg.fast_interval);
            sodfs_pkg::REG_SLOW_INTERVAL: prdata = 32'(cfg_reg.slow_interval);
            sodfs_pkg::REG_THRESHOLD:     prdata = 32'(cfg_reg.threshold);
            sodfs_pkg::REG_FRAME_ID:      prdata = 32'(cfg_reg.frame_id);
            sodfs_pkg::REG_ANALOG_HASH:   prdata = cfg_reg.analog_hash;
            sodfs_pkg::REG_SWITCH_HASH:   prdata = cfg_reg.switch_hash;
            default:                      prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.read_interval <= sodfs_pkg::READ_INTERVAL_RST;
            cfg_reg.fast_interval <= sodfs_pkg::FAST_INTERVAL_RST;
            cfg_reg.slow_interval <= sodfs_pkg::SLOW_INTERVAL_RST;
            cfg_reg.threshold     <= sodfs_pkg::THRESHOLD_RST;
            cfg_reg.frame_id      <= sodfs_pkg::FRAME_ID_RST;
            cfg_reg.analog_hash   <= sodfs_pkg::ANALOG_HASH_RST;
            cfg_reg.switch_hash   <= sodfs_pkg::SWITCH_HASH_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/sodfs_core.sv
// ----------------------------------------------------------------------------
// sodfs_core
// Input register, channel state and per-tick frame decision.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sodfs_core #(
    parameter int SAMPLE_BITS = sodfs_pkg::SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = sodfs_pkg::TIME_BITS_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  sodfs_pkg::cfg_t      cfg,
    sodfs_tick_if.sink           tick,
    input  wire logic            room,
    output sodfs_pkg::push_t     push
);

    localparam int CMP_BITS = (SAMPLE_BITS > sodfs_pkg::THRESH_BITS) ?
                              SAMPLE_BITS : sodfs_pkg::THRESH_BITS;

    logic                   item_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;
    logic                   level_reg;

    logic [TIME_BITS-1:0]   time_now_reg;
    logic [TIME_BITS-1:0]   last_latch_reg;
    logic [SAMPLE_BITS-1:0] held_analog_reg;
    logic                   held_switch_reg;
    logic [SAMPLE_BITS-1:0] a_sent_value_reg;
    logic [TIME_BITS-1:0]   a_sent_time_reg;
    logic                   a_pending_reg;
    logic                   s_sent_value_reg;
    logic [TIME_BITS-1:0]   s_sent_time_reg;
    logic                   s_pending_reg;

    logic                   fire;
    logic                   latch;
    logic [SAMPLE_BITS-1:0] held_analog_next;
    logic                   held_switch_next;
    logic [SAMPLE_BITS-1:0] diff;
    logic                   a_pend_mid;
    logic                   s_pend_mid;
    logic [TIME_BITS-1:0]   a_elapsed;
    logic [TIME_BITS-1:0]   s_elapsed;
    logic                   a_due;
    logic                   s_due;
    sodfs_pkg::frame_t      a_frame;
    sodfs_pkg::frame_t      s_frame;

    assign fire       = item_valid_reg & room;
    assign tick.ready = ~item_valid_reg | fire;

    always_comb
    begin
        latch = (time_now_reg - last_latch_reg) >= TIME_BITS'(cfg.read_interval);
        held_analog_next = latch ? sample_reg : held_analog_reg;
        held_switch_next = latch ? ~level_reg : held_switch_reg;

        diff = (held_analog_next >= a_sent_value_reg) ?
               (held_analog_next - a_sent_value_reg) :
               (a_sent_value_reg - held_analog_next);

        a_pend_mid = a_pending_reg |
                     (latch & (CMP_BITS'(diff) >= CMP_BITS'(cfg.threshold)));
        s_pend_mid = s_pending_reg | (latch & (held_switch_next != s_sent_value_reg));

        a_elapsed = time_now_reg - a_sent_time_reg;
        s_elapsed = time_now_reg - s_sent_time_reg;
        a_due = a_elapsed >= TIME_BITS'(a_pend_mid ? cfg.fast_interval : cfg.slow_interval);
        s_due = s_elapsed >= TIME_BITS'(s_pend_mid ? cfg.fast_interval : cfg.slow_interval);

        a_frame.frame_id     = cfg.frame_id;
        a_frame.channel      = sodfs_pkg::CH_ANALOG;
        a_frame.payload      = {cfg.analog_hash, sodfs_pkg::int_to_single(
                                    sodfs_pkg::MAX_SAMPLE_BITS'(held_analog_next))};
        a_frame.last_of_tick = ~s_due;

        s_frame.frame_id     = cfg.frame_id;
        s_frame.channel      = sodfs_pkg::CH_SWITCH;
        s_frame.payload      = {cfg.switch_hash, held_switch_next ?
                                    sodfs_pkg::SINGLE_ONE : sodfs_pkg::SINGLE_ZERO};
        s_frame.last_of_tick = 1'b1;

        push.count  = fire ? ({1'b0, a_due} + {1'b0, s_due}) : 2'd0;
        push.first  = a_due ? a_frame : s_frame;
        push.second = s_frame;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            item_valid_reg <= 1'b0;
        end else if (tick.ready) begin
            item_valid_reg <= tick.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tick.valid && tick.ready) begin
            sample_reg <= tick.analog_sample;
            level_reg  <= tick.switch_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            time_now_reg     <= '0;
            last_latch_reg   <= '0;
            held_analog_reg  <= '0;
            held_switch_reg  <= 1'b0;
            a_sent_value_reg <= '0;
            a_sent_time_reg  <= '0;
            a_pending_reg    <= 1'b1;
            s_sent_value_reg <= 1'b0;
            s_sent_time_reg  <= '0;
            s_pending_reg    <= 1'b1;
        end else if (fire) begin
            time_now_reg    <= time_now_reg + TIME_BITS'(1);
            held_analog_reg <= held_analog_next;
            held_switch_reg <= held_switch_next;
            if (latch) begin
                last_latch_reg <= time_now_reg;
            end
            a_pending_reg <= a_pend_mid & ~a_due;
            s_pending_reg <= s_pend_mid & ~s_due;
            if (a_due) begin
                a_sent_value_reg <= held_analog_next;
                a_sent_time_reg  <= time_now_reg;
            end
            if (s_due) begin
                s_sent_value_reg <= held_switch_next;
                s_sent_time_reg  <= time_now_reg;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/sodfs_frame_fifo.sv
// ----------------------------------------------------------------------------
// sodfs_frame_fifo
// Small frame queue: takes up to two frames a cycle, sends one a cycle while frame.ready is high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sodfs_frame_fifo (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  sodfs_pkg::push_t   push,
    output logic               room,
    sodfs_frame_if.source      frame
);

    localparam int DEPTH    = sodfs_pkg::FIFO_DEPTH;
    localparam int PTR_BITS = $clog2(DEPTH);
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    sodfs_pkg::frame_t     mem_reg [DEPTH];
    logic [PTR_BITS-1:0]   wr_ptr_reg;
    logic [PTR_BITS-1:0]   wr_ptr_next;
    logic [PTR_BITS-1:0]   rd_ptr_reg;
    logic [PTR_BITS-1:0]   rd_ptr_next;
    logic [CNT_BITS-1:0]   count_reg;
    logic [CNT_BITS-1:0]   count_next;
    logic [PTR_BITS-1:0]   wr_ptr_plus;
    logic                  pop;
    sodfs_pkg::frame_t     head;

    assign head               = mem_reg[rd_ptr_reg];
    assign frame.valid        = (count_reg != '0);
    assign frame.frame_id     = head.frame_id;
    assign frame.channel      = head.channel;
    assign frame.payload      = head.payload;
    assign frame.last_of_tick = head.last_of_tick;

    assign pop         = frame.valid & frame.ready;
    assign room        = (count_reg <= CNT_BITS'(DEPTH - 2));
    assign wr_ptr_plus = wr_ptr_reg + PTR_BITS'(1);

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + PTR_BITS'(push.count);
        rd_ptr_next = rd_ptr_reg + PTR_BITS'(pop);
        count_next  = count_reg + CNT_BITS'(push.count) - CNT_BITS'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.count != 2'd0) begin
            mem_reg[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            mem_reg[wr_ptr_plus] <= push.second;
        end
    end

endmodule

`default_nettype wire

>>> bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives millisecond ticks into the send-on-delta frame scheduler and checks
// every emitted frame against an independent model of its latch and send
// schedule. Both channels idle and stall at random. The registers are changed
// between phases over APB and read back once all of them are written.
// ----------------------------------------------------------------------------

module testbench;
    import sodfs_pkg::*;

    localparam int SAMPLE_MAX        = (1 << SAMPLE_BITS_DEF) - 1;
    localparam int HOLD_CYCLES       = 300;
    localparam int SETTLE_CYCLES     = 12;
    localparam int STALL_LIMIT       = 5000;
    localparam int RESET_PHASE_TICKS = 200;
    localparam int RANDOM_PHASES     = 14;
    localparam int TICKS_PER_PHASE   = 95;
    localparam int MAX_CFG_PHASE     = 3;
    localparam int NO_IDLE_PHASE     = 5;
    localparam int PRESSURE_PHASE    = 8;
    localparam int MIN_CFG_PHASE     = 10;
    localparam int DIRECTED_ROWS     = 22;
    localparam int DIRECTED_SPLIT    = 10;
    localparam logic [2:0] REG_SPARE = 3'd7;

    typedef struct {
        logic [SAMPLE_BITS_DEF-1:0] counts;
        logic                       level;
        bit                         typed;
        logic [SINGLE_BITS-1:0]     analog_single;
        logic [SINGLE_BITS-1:0]     switch_single;
    } tick_row_t;

    tick_row_t directed_ticks [DIRECTED_ROWS] = '{
        '{10'd0,    1'b0, 1'b1, 32'h0000_0000, 32'h3F80_0000},
        '{10'd1023, 1'b1, 1'b1, 32'h447F_C000, 32'h0000_0000},
        '{10'd1,    1'b0, 1'b1, 32'h3F80_0000, 32'h3F80_0000},
        '{10'd512,  1'b1, 1'b1, 32'h4400_0000, 32'h0000_0000},
        '{10'd2,    1'b1, 1'b1, 32'h4000_0000, 32'h0000_0000},
        '{10'd3,    1'b0, 1'b1, 32'h4040_0000, 32'h3F80_0000},
        '{10'd341,  1'b1, 1'b0, 32'h0,         32'h0},
        '{10'd682,  1'b0, 1'b0, 32'h0,         32'h0},
        '{10'd1023, 1'b1, 1'b1, 32'h447F_C000, 32'h0000_0000},
        '{10'd1023, 1'b1, 1'b1, 32'h447F_C000, 32'h0000_0000},
        '{10'd0,    1'b1, 1'b0, 32'h0,         32'h0},
        '{10'd1023, 1'b0, 1'b0, 32'h0,         32'h0},
        '{10'd1023, 1'b0, 1'b0, 32'h0,         32'h0},
        '{10'd0,    1'b1, 1'b0, 32'h0,         32'h0},
        '{10'd5,    1'b1, 1'b0, 32'h0,         32'h0},
        '{10'd1000, 1'b0, 1'b0, 32'h0,         32'h0},
        '{10'd1000, 1'b0, 1'b0, 32'h0,         32'h0},
        '{10'd1,    1'b1, 1'b0, 32'h0,         32'h0},
        '{10'd1022, 1'b0, 1'b0, 32'h0,         32'h0},
        '{10'd1023, 1'b1, 1'b0, 32'h0,         32'h0},
        '{10'd0,    1'b0, 1'b0, 32'h0,         32'h0},
        '{10'd512,  1'b1, 1'b0, 32'h0,         32'h0}
    };

    logic clk;
    logic rst_n;
    logic psel;
    logic penable;
    logic pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic pready;

    sodfs_tick_if  tick_ch ();
    sodfs_frame_if frame_ch ();

    send_on_delta_frame_scheduler_unit i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .tick    (tick_ch),
        .frame   (frame_ch)
    );

    cfg_t                       regs_mirror;
    logic [31:0]                setting_words [7];
    logic [TIME_BITS_DEF-1:0]   tick_clock;
    logic [TIME_BITS_DEF-1:0]   latch_stamp;
    logic [SAMPLE_BITS_DEF-1:0] held_counts;
    logic                       held_active;
    logic [SAMPLE_BITS_DEF-1:0] analog_last_counts;
    logic [TIME_BITS_DEF-1:0]   analog_last_stamp;
    logic                       analog_dirty;
    logic                       switch_last_active;
    logic [TIME_BITS_DEF-1:0]   switch_last_stamp;
    logic                       switch_dirty;

    frame_t tick_frames [$];
    frame_t frames_due [$];

    bit                     tick_typed;
    logic [SINGLE_BITS-1:0] typed_analog_single;
    logic [SINGLE_BITS-1:0] typed_switch_single;
    bit                     no_idle;
    bit                     hold_frames;
    int                     fail_count;
    int                     stall_cycles;

    function automatic logic [SINGLE_BITS-1:0] count_to_single(
        input logic [SAMPLE_BITS_DEF-1:0] v
    );
        int          msb;
        logic [31:0] shifted;
        msb = 0;
        for (int i = 0; i < SAMPLE_BITS_DEF; i++) begin
            if (v[i]) begin
                msb = i;
            end
        end
        shifted = 32'(v) << (23 - msb);
        if (v == '0) begin
            return SINGLE_ZERO;
        end
        return {1'b0, 8'(127 + msb), shifted[22:0]};
    endfunction

    function automatic void reset_model();
        regs_mirror.read_interval = READ_INTERVAL_RST;
        regs_mirror.fast_interval = FAST_INTERVAL_RST;
        regs_mirror.slow_interval = SLOW_INTERVAL_RST;
        regs_mirror.threshold     = THRESHOLD_RST;
        regs_mirror.frame_id      = FRAME_ID_RST;
        regs_mirror.analog_hash   = ANALOG_HASH_RST;
        regs_mirror.switch_hash   = SWITCH_HASH_RST;
        tick_clock         = '0;
        latch_stamp        = '0;
        held_counts        = '0;
        held_active        = 1'b0;
        analog_last_counts = '0;
        analog_last_stamp  = '0;
        analog_dirty       = 1'b1;
        switch_last_active = 1'b0;
        switch_last_stamp  = '0;
        switch_dirty       = 1'b1;
    endfunction

    // Frames that one tick sends, in order analog then switch.
    function automatic void schedule_tick(
        input logic [SAMPLE_BITS_DEF-1:0] counts,
        input logic                       level
    );
        logic [SAMPLE_BITS_DEF-1:0] swing;
        logic [INTERVAL_BITS-1:0]   spacing;
        frame_t                     f;
        tick_frames.delete();
        if (tick_clock - latch_stamp >= regs_mirror.read_interval) begin
            latch_stamp = tick_clock;
            held_counts = counts;
            held_active = !level;
            swing = (held_counts >= analog_last_counts) ? held_counts - analog_last_counts
                                                        : analog_last_counts - held_counts;
            if (swing >= regs_mirror.threshold) begin
                analog_dirty = 1'b1;
            end
            if (held_active != switch_last_active) begin
                switch_dirty = 1'b1;
            end
        end
        spacing = analog_dirty ? regs_mirror.fast_interval : regs_mirror.slow_interval;
        if (tick_clock - analog_last_stamp >= spacing) begin
            f.frame_id     = regs_mirror.frame_id;
            f.channel      = CH_ANALOG;
            f.payload      = {regs_mirror.analog_hash, count_to_single(held_counts)};
            f.last_of_tick = 1'b0;
            tick_frames.push_back(f);
            analog_last_counts = held_counts;
            analog_last_stamp  = tick_clock;
            analog_dirty       = 1'b0;
        end
        spacing = switch_dirty ? regs_mirror.fast_interval : regs_mirror.slow_interval;
        if (tick_clock - switch_last_stamp >= spacing) begin
            f.frame_id     = regs_mirror.frame_id;
            f.channel      = CH_SWITCH;
            f.payload      = {regs_mirror.switch_hash, held_active ? SINGLE_ONE : SINGLE_ZERO};
            f.last_of_tick = 1'b0;
            tick_frames.push_back(f);
            switch_last_active = held_active;
            switch_last_stamp  = tick_clock;
            switch_dirty       = 1'b0;
        end
        if (tick_frames.size() > 0) begin
            tick_frames[tick_frames.size() - 1].last_of_tick = 1'b1;
        end
        tick_clock = tick_clock + 1'b1;
    endfunction

    function automatic logic [31:0] register_word(input logic [2:0] idx);
        case (idx)
            REG_READ_INTERVAL: return 32'(regs_mirror.read_interval);
            REG_FAST_INTERVAL: return 32'(regs_mirror.fast_interval);
            REG_SLOW_INTERVAL: return 32'(regs_mirror.slow_interval);
            REG_THRESHOLD:     return 32'(regs_mirror.threshold);
            REG_FRAME_ID:      return 32'(regs_mirror.frame_id);
            REG_ANALOG_HASH:   return regs_mirror.analog_hash;
            REG_SWITCH_HASH:   return regs_mirror.switch_hash;
            default:           return '0;
        endcase
    endfunction

    task automatic write_register(input logic [2:0] idx, input logic [31:0] word);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = word;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        case (idx)
            REG_READ_INTERVAL: regs_mirror.read_interval = word[INTERVAL_BITS-1:0];
            REG_FAST_INTERVAL: regs_mirror.fast_interval = word[INTERVAL_BITS-1:0];
            REG_SLOW_INTERVAL: regs_mirror.slow_interval = word[INTERVAL_BITS-1:0];
            REG_THRESHOLD:     regs_mirror.threshold     = word[THRESH_BITS-1:0];
            REG_FRAME_ID:      regs_mirror.frame_id      = word[ID_BITS-1:0];
            REG_ANALOG_HASH:   regs_mirror.analog_hash   = word;
            REG_SWITCH_HASH:   regs_mirror.switch_hash   = word;
            default:           ;
        endcase
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic check_register(input logic [2:0] idx);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata !== register_word(idx)) begin
            $display("%0t ns: register %0d expected %h got %h",
                     $time, idx, register_word(idx), prdata);
            fail_count++;
        end
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic program_registers();
        for (int i = REG_READ_INTERVAL; i <= REG_SWITCH_HASH; i++) begin
            write_register(3'(i), setting_words[i]);
        end
        write_register(REG_SPARE, $urandom);
        for (int i = REG_READ_INTERVAL; i <= REG_SWITCH_HASH; i++) begin
            check_register(3'(i));
        end
    endtask

    function automatic void draw_settings(input int phase);
        int rd;
        int fast;
        int slow;
        int thr;
        rd   = $urandom_range(1, 6);
        fast = $urandom_range(0, 12);
        slow = $urandom_range(fast, 40);
        thr  = ($urandom_range(0, 99) < 70) ? $urandom_range(0, 8) : $urandom_range(0, 1023);
        if (phase == MAX_CFG_PHASE) begin
            rd   = 65535;
            fast = 65535;
            slow = 65535;
            thr  = 1023;
        end else if (phase == MIN_CFG_PHASE) begin
            rd   = 1;
            fast = 1;
            slow = 1;
            thr  = 0;
        end else if (phase == PRESSURE_PHASE) begin
            rd   = 0;
            fast = 0;
            slow = 0;
        end
        setting_words[REG_READ_INTERVAL] = {16'($urandom), 16'(rd)};
        setting_words[REG_FAST_INTERVAL] = {16'($urandom), 16'(fast)};
        setting_words[REG_SLOW_INTERVAL] = {16'($urandom), 16'(slow)};
        setting_words[REG_THRESHOLD]     = {22'($urandom), 10'(thr)};
        setting_words[REG_FRAME_ID]      = $urandom;
        setting_words[REG_ANALOG_HASH]   = $urandom;
        setting_words[REG_SWITCH_HASH]   = $urandom;
        if (phase == MAX_CFG_PHASE) begin
            setting_words[REG_FRAME_ID]    = 32'h7FF;
            setting_words[REG_ANALOG_HASH] = 32'hFFFF_FFFF;
            setting_words[REG_SWITCH_HASH] = 32'hFFFF_FFFF;
        end else if (phase == MIN_CFG_PHASE) begin
            setting_words[REG_FRAME_ID]    = 32'h0;
            setting_words[REG_ANALOG_HASH] = 32'h0;
            setting_words[REG_SWITCH_HASH] = 32'h0;
        end
    endfunction

    task automatic send_tick(
        input logic [SAMPLE_BITS_DEF-1:0] counts,
        input logic                       level,
        input bit                         typed,
        input logic [SINGLE_BITS-1:0]     analog_single,
        input logic [SINGLE_BITS-1:0]     switch_single
    );
        @(negedge clk);
        while (!no_idle && $urandom_range(0, 99) < 33) begin
            tick_ch.valid = 1'b0;
            @(negedge clk);
        end
        tick_ch.valid         = 1'b1;
        tick_ch.analog_sample = counts;
        tick_ch.switch_level  = level;
        tick_typed            = typed;
        typed_analog_single   = analog_single;
        typed_switch_single   = switch_single;
        do @(posedge clk); while (!tick_ch.ready);
    endtask

    // Lets every expected frame out and any tick without frames settle.
    task automatic quiesce();
        @(negedge clk);
        tick_ch.valid = 1'b0;
        tick_typed    = 1'b0;
        while (frames_due.size() != 0) begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_random_ticks(input int count);
        logic [SAMPLE_BITS_DEF-1:0] counts;
        logic                       level;
        int                         span;
        int                         next;
        int                         r;
        counts = held_counts;
        level  = !held_active;
        for (int n = 0; n < count; n++) begin
            r    = $urandom_range(0, 99);
            span = int'(regs_mirror.threshold) + 2;
            if (span > 200) begin
                span = 200;
            end
            if (r < 6) begin
                counts = $urandom_range(0, SAMPLE_MAX);
            end else if (r < 9) begin
                counts = (r == 6) ? '0 : SAMPLE_BITS_DEF'(SAMPLE_MAX);
            end else begin
                next = int'(counts) + int'($urandom_range(0, 2 * span)) - span;
                if (next < 0) begin
                    next = 0;
                end else if (next > SAMPLE_MAX) begin
                    next = SAMPLE_MAX;
                end
                counts = SAMPLE_BITS_DEF'(next);
            end
            if ($urandom_range(0, 99) < 12) begin
                level = !level;
            end
            send_tick(counts, level, 1'b0, '0, '0);
        end
    endtask

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        frame_t got;
        frame_t want;
        frame_t f;
        if (rst_n) begin
            if (frame_ch.valid && frame_ch.ready) begin
                got.frame_id     = frame_ch.frame_id;
                got.channel      = frame_ch.channel;
                got.payload      = frame_ch.payload;
                got.last_of_tick = frame_ch.last_of_tick;
                if (frames_due.size() == 0) begin
                    $display("%0t ns: frame expected none got %h", $time, got);
                    fail_count++;
                end else begin
                    want = frames_due.pop_front();
                    if (got.frame_id !== want.frame_id) begin
                        $display("%0t ns: frame_id expected %h got %h",
                                 $time, want.frame_id, got.frame_id);
                        fail_count++;
                    end
                    if (got.channel !== want.channel) begin
                        $display("%0t ns: channel expected %h got %h",
                                 $time, want.channel, got.channel);
                        fail_count++;
                    end
                    if (got.payload !== want.payload) begin
                        $display("%0t ns: payload expected %h got %h",
                                 $time, want.payload, got.payload);
                        fail_count++;
                    end
                    if (got.last_of_tick !== want.last_of_tick) begin
                        $display("%0t ns: last_of_tick expected %h got %h",
                                 $time, want.last_of_tick, got.last_of_tick);
                        fail_count++;
                    end
                end
            end
            if (tick_ch.valid && tick_ch.ready) begin
                schedule_tick(tick_ch.analog_sample, tick_ch.switch_level);
                if (tick_typed) begin
                    tick_frames.delete();
                    f.frame_id     = regs_mirror.frame_id;
                    f.channel      = CH_ANALOG;
                    f.payload      = {regs_mirror.analog_hash, typed_analog_single};
                    f.last_of_tick = 1'b0;
                    tick_frames.push_back(f);
                    f.channel      = CH_SWITCH;
                    f.payload      = {regs_mirror.switch_hash, typed_switch_single};
                    f.last_of_tick = 1'b1;
                    tick_frames.push_back(f);
                end
                foreach (tick_frames[k]) begin
                    frames_due.push_back(tick_frames[k]);
                end
            end
        end
    end

    initial begin
        frame_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_frames) begin
                frame_ch.ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_frames = 1'b0;
            end
            frame_ch.ready = no_idle || ($urandom_range(0, 99) >= 33);
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (tick_ch.valid && tick_ch.ready) || (frame_ch.valid && frame_ch.ready)
            || psel) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        wait (stall_cycles >= STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        rst_n                 = 1'b0;
        psel                  = 1'b0;
        penable               = 1'b0;
        pwrite                = 1'b0;
        paddr                 = '0;
        pwdata                = '0;
        tick_ch.valid         = 1'b0;
        tick_ch.analog_sample = '0;
        tick_ch.switch_level  = 1'b1;
        tick_typed            = 1'b0;
        typed_analog_single   = '0;
        typed_switch_single   = '0;
        no_idle               = 1'b0;
        hold_frames           = 1'b0;
        fail_count            = 0;
        stall_cycles          = 0;
        reset_model();
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        for (int i = REG_READ_INTERVAL; i <= REG_SWITCH_HASH; i++) begin
            check_register(3'(i));
        end
        run_random_ticks(RESET_PHASE_TICKS);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (i == 0) begin
                quiesce();
                setting_words = '{32'd0, 32'd0, 32'd0, 32'd0, 32'h7FF, 32'hFFFF_FFFF, 32'd0};
                program_registers();
            end else if (i == DIRECTED_SPLIT) begin
                quiesce();
                setting_words = '{32'h1234_0004, 32'd2, 32'd7, 32'hFFFF_FFFF,
                                  32'hFFFF_F800, 32'hA5A5_5A5A, 32'h0000_0001};
                program_registers();
            end
            send_tick(directed_ticks[i].counts, directed_ticks[i].level,
                      directed_ticks[i].typed, directed_ticks[i].analog_single,
                      directed_ticks[i].switch_single);
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            quiesce();
            draw_settings(p);
            program_registers();
            no_idle = (p == NO_IDLE_PHASE);
            if (p == PRESSURE_PHASE) begin
                hold_frames = 1'b1;
            end
            run_random_ticks(TICKS_PER_PHASE);
        end
        no_idle = 1'b0;
        quiesce();

        if (fail_count == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
